// File: rtl/core/lppd_pkg.sv
// Shared types and constants for the length-prefixed packet deframer.
`timescale 1ns / 1ps
`default_nettype none

package lppd_pkg;

   localparam int unsigned BYTE_BITS = 8;
   localparam int unsigned LEN_BITS  = 16;

   localparam logic [LEN_BITS-1:0] DEFAULT_MAX_LEN = 16'd1514;

   // Result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_ERROR   = 1'b1;

   typedef enum logic [2:0] {
      PH_HDR_LO  = 3'd0,
      PH_HDR_HI  = 3'd1,
      PH_PAYLOAD = 3'd2,
      PH_PAD     = 3'd3,
      PH_DISCARD = 3'd4
   } phase_type;

   typedef struct packed {
      logic                 kind;
      logic [BYTE_BITS-1:0] payload_byte;
      logic                 packet_first;
      logic                 packet_last;
      logic [LEN_BITS-1:0]  declared_length;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/core/lppd_parser.sv
// Header, payload, pad and discard state machine of the deframer.
`timescale 1ns / 1ps
`default_nettype none

module lppd_parser (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             accept,
   input  wire logic [lppd_pkg::BYTE_BITS-1:0]   rx_byte,
   input  wire logic                             transfer_end,
   input  wire logic [lppd_pkg::LEN_BITS-1:0]    max_len,
   output logic                                  res_valid,
   output lppd_pkg::result_type                  res
);
   import lppd_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [BYTE_BITS-1:0]  hdr_low_ff, hdr_low_in;
   logic [LEN_BITS-1:0]   remaining_ff, remaining_in;
   logic [LEN_BITS-1:0]   cur_len_ff, cur_len_in;
   logic                  offset_odd_ff, offset_odd_in;

   logic [LEN_BITS-1:0]   hdr_len;
   logic                  odd_next;

   assign hdr_len  = {rx_byte, hdr_low_ff};
   assign odd_next = ~offset_odd_ff;

   always_comb begin
      phase_in      = phase_ff;
      hdr_low_in    = hdr_low_ff;
      remaining_in  = remaining_ff;
      cur_len_in    = cur_len_ff;
      offset_odd_in = offset_odd_ff;
      res_valid     = 1'b0;
      res           = '0;
      if (accept) begin
         offset_odd_in = odd_next;
         unique case (phase_ff)
            PH_HDR_LO: begin
               hdr_low_in = rx_byte;
               phase_in   = PH_HDR_HI;
            end
            PH_HDR_HI: begin
               if (hdr_len > max_len) begin
                  res_valid           = 1'b1;
                  res.kind            = KIND_ERROR;
                  res.declared_length = hdr_len;
                  phase_in            = PH_DISCARD;
               end else if (hdr_len == '0) begin
                  phase_in = PH_HDR_LO;
               end else begin
                  cur_len_in   = hdr_len;
                  remaining_in = hdr_len;
                  phase_in     = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               res_valid           = 1'b1;
               res.kind            = KIND_PAYLOAD;
               res.payload_byte    = rx_byte;
               res.packet_first    = (remaining_ff == cur_len_ff);
               res.packet_last     = (remaining_ff == LEN_BITS'(1));
               res.declared_length = cur_len_ff;
               remaining_in        = remaining_ff - LEN_BITS'(1);
               if (remaining_ff == LEN_BITS'(1)) begin
                  // odd end of payload: skip one pad byte
                  phase_in = odd_next ? PH_PAD : PH_HDR_LO;
               end
            end
            PH_PAD: begin
               phase_in = PH_HDR_LO;
            end
            PH_DISCARD: begin
               phase_in = PH_DISCARD;
            end
            default: begin
               phase_in = PH_HDR_LO;
            end
         endcase
         if (transfer_end) begin
            offset_odd_in = 1'b0;
            if (!(phase_in == PH_PAYLOAD && remaining_in != '0)) begin
               phase_in = PH_HDR_LO;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HDR_LO;
         hdr_low_ff    <= '0;
         remaining_ff  <= '0;
         cur_len_ff    <= '0;
         offset_odd_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         hdr_low_ff    <= hdr_low_in;
         remaining_ff  <= remaining_in;
         cur_len_ff    <= cur_len_in;
         offset_odd_ff <= offset_odd_in;
      end
   end

`ifndef SYNTHESIS
   a_payload_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (remaining_ff != '0 && remaining_ff <= cur_len_ff))
      else $error("payload phase with no bytes left");

   a_end_resets_parity: assert property (@(posedge clock) disable iff (reset)
      (accept && transfer_end) |=> (offset_odd_ff == 1'b0))
      else $error("offset parity not cleared at transfer end");

   a_error_only_from_header: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.kind == KIND_ERROR) |-> (phase_ff == PH_HDR_HI))
      else $error("error result outside header check");
`endif

endmodule

`default_nettype wire

// File: rtl/core/lppd_out_buf.sv
// Two-entry result register with skid stage for the deframer output.
`timescale 1ns / 1ps
`default_nettype none

module lppd_out_buf (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire lppd_pkg::result_type push_data,
   output logic                      can_push,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output lppd_pkg::result_type      out_data
);
   import lppd_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;

   assign can_push  = ~skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (main_valid_ff && out_ready) begin
         main_valid_in = 1'b0;
      end
      if (skid_valid_ff && !main_valid_in) begin
         main_in       = skid_ff;
         main_valid_in = 1'b1;
         skid_valid_in = 1'b0;
      end
      if (push) begin
         if (!main_valid_in) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !skid_valid_ff)
      else $error("result pushed into full buffer");

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held with empty main entry");

   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && out_ready) |=> (main_valid_ff && main_ff == $past(skid_ff)))
      else $error("skid entry lost on pop");
`endif

endmodule

`default_nettype wire

// File: rtl/core/length_prefixed_packet_deframer_unit.sv
// Top level of the length-prefixed packet deframer.
`timescale 1ns / 1ps
`default_nettype none

// Length-prefixed packet deframer. Takes one received byte per beat on the
// req_ channel (req_tlast marks the last byte of a transfer). Each packet in
// a transfer opens with a 2-byte little-endian length; packets are padded so
// the next header starts at an even offset in the transfer. Payload bytes
// stream out on the rsp_ channel one beat each, with first/last marks and the
// declared length; a packet may continue across any number of transfers.
// A zero-length header yields nothing, and a lone leftover byte at the end
// of a transfer is dropped. A header longer than the max length register
// (csr_data, reset 1514) yields one error beat (rsp_tuser = 1) and the rest
// of that transfer is dropped. Throughput is one byte per clock while the
// skid stage is free: the header and payload state machine updates once
// per accepted beat, and a two-entry output buffer (result register plus
// skid stage) keeps req_tready high while one result waits on rsp_tready.
// Results are registered in the output buffer. Write csr_ only while the
// block is idle; csr_ready is always high. No clearing pass follows reset.
module length_prefixed_packet_deframer_unit (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic        req_tlast,   // transfer_end

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [7:0] payload_byte, [8] packet_first,
                                         // [24:9] declared_length, [31:25] zero
   output logic             rsp_tuser,   // kind: 0 payload, 1 oversize error
   output logic             rsp_tlast,   // packet_last

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data     // max_packet_length
);
   import lppd_pkg::*;

   logic [LEN_BITS-1:0] max_len_ff, max_len_in;
   logic                req_accept;
   logic                res_valid;
   result_type          res;
   logic                can_push;
   result_type          out_res;

   // Config register always ready; the user must write only while idle, the block does not enforce it.
   assign csr_ready = 1'b1;

   always_comb begin
      max_len_in = max_len_ff;
      if (csr_valid) begin
         max_len_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= DEFAULT_MAX_LEN;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   // Accept a byte whenever the skid stage is free.
   assign req_tready = can_push;
   assign req_accept = req_tvalid & req_tready;

   lppd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .rx_byte      (req_tdata),
      .transfer_end (req_tlast),
      .max_len      (max_len_ff),
      .res_valid    (res_valid),
      .res          (res)
   );

   lppd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .can_push  (can_push),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_res)
   );

   // Pack the result beat.
   assign rsp_tdata = {7'd0, out_res.declared_length, out_res.packet_first,
                       out_res.payload_byte};
   assign rsp_tuser = out_res.kind;
   assign rsp_tlast = out_res.packet_last;

`ifndef SYNTHESIS
   a_error_beat_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_ERROR)
         |-> (rsp_tdata[8:0] == 9'd0 && !rsp_tlast))
      else $error("error beat carries payload marks");

   a_result_from_input: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_tvalid)) |-> $past(req_accept))
      else $error("result beat without accepted input");

   a_error_over_limit: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.kind == KIND_ERROR) |-> (res.declared_length > max_len_ff))
      else $error("error result for length within limit");
`endif

endmodule

`default_nettype wire
